### rtl/core/signed_int_to_decimal_ascii_top_assert.svh
// Assertion macros shared by the RTL modules of the decimal text converter.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked outside of reset.
`define SIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define SIDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SIDA_ASSERT(lbl, prop, msg)
`define SIDA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/sida_pkg.sv
`timescale 1ns / 1ps
package sida_pkg;

  localparam int VALUE_W   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int IDX_W     = $clog2(NUM_DIGITS);
  localparam int LEN_W     = 4;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // Converter control states.
  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_t;

  // Character emitter control states.
  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_DIGIT
  } emit_state_t;

  // Finished conversion handed from the converter to the emitter.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             negative;
  } conv_result_t;

endpackage

### rtl/core/sida_bin2bcd.sv
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"
module sida_bin2bcd (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [sida_pkg::VALUE_W-1:0] value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sida_pkg::conv_result_t res
);

  sida_pkg::conv_state_t state;
  sida_pkg::conv_state_t state_next;

  logic [sida_pkg::VALUE_W-1:0]   mag;
  logic [sida_pkg::BCD_W-1:0]     bcd;
  logic [sida_pkg::BCD_W-1:0]     bcd_adj;
  logic [sida_pkg::BIT_CNT_W-1:0] count;
  logic                           negative;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
          bcd[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
          bcd[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      sida_pkg::CONV_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = sida_pkg::CONV_RUN;
        end
      end
      sida_pkg::CONV_RUN: begin
        if (count == '0) begin
          state_next = sida_pkg::CONV_DONE;
        end
      end
      sida_pkg::CONV_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sida_pkg::CONV_IDLE;
        end
      end
      default: begin
        state_next = sida_pkg::CONV_IDLE;
      end
    endcase
  end

  // Magnitude shifts out one bit per cycle, most significant first, into the BCD digits.
  always_ff @(posedge clk) begin
    if (state == sida_pkg::CONV_IDLE && in_valid) begin
      negative <= value[sida_pkg::VALUE_W-1];
      mag      <= value[sida_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      bcd      <= '0;
      count    <= sida_pkg::BIT_CNT_W'(sida_pkg::VALUE_W - 1);
    end else if (state == sida_pkg::CONV_RUN) begin
      bcd   <= {bcd_adj[sida_pkg::BCD_W-2:0], mag[sida_pkg::VALUE_W-1]};
      mag   <= {mag[sida_pkg::VALUE_W-2:0], 1'b0};
      count <= count - 1'b1;
    end
  end

  assign res.bcd      = bcd;
  assign res.negative = negative;

  // The magnitude never exceeds 2147483648, so the top digit is at most two.
  `SIDA_ASSERT(a_top_digit_range, res_valid |-> (bcd[sida_pkg::BCD_W-1 -: 4] <= 4'd2), "top BCD digit out of range")
  // A result only appears after the last shift of a conversion.
  `SIDA_ASSERT(a_done_after_run, $rose(res_valid) |-> $past(state == sida_pkg::CONV_RUN), "result without conversion")
  // A waiting result holds until the emitter takes it.
  `SIDA_ASSERT(a_result_holds, (res_valid && !res_ready) |=> $stable(res), "result changed while waiting")

endmodule

### rtl/core/sida_emit.sv
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"
module sida_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  output logic                  res_ready,
  input  sida_pkg::conv_result_t res,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            character,
  output logic [sida_pkg::LEN_W-1:0] text_length,
  output logic                  is_last
);

  sida_pkg::emit_state_t state;
  sida_pkg::emit_state_t state_next;

  logic [sida_pkg::BCD_W-1:0] bcd;
  logic [sida_pkg::IDX_W-1:0] idx;
  logic [sida_pkg::IDX_W-1:0] top_idx;
  logic [sida_pkg::LEN_W-1:0] len;
  logic [sida_pkg::DIGIT_W-1:0] digit;

  // Position of the leading nonzero digit; zero keeps one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (res.bcd[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
        top_idx = sida_pkg::IDX_W'(i);
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::EMIT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    res_ready  = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      sida_pkg::EMIT_IDLE: begin
        res_ready = 1'b1;
        if (res_valid) begin
          state_next = res.negative ? sida_pkg::EMIT_SIGN : sida_pkg::EMIT_DIGIT;
        end
      end
      sida_pkg::EMIT_SIGN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = sida_pkg::EMIT_DIGIT;
        end
      end
      sida_pkg::EMIT_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready && idx == '0) begin
          state_next = sida_pkg::EMIT_IDLE;
        end
      end
      default: begin
        state_next = sida_pkg::EMIT_IDLE;
      end
    endcase
  end

  // Digits are stepped from the leading one down to the units digit.
  always_ff @(posedge clk) begin
    if (state == sida_pkg::EMIT_IDLE && res_valid) begin
      bcd <= res.bcd;
      idx <= top_idx;
      len <= sida_pkg::LEN_W'(top_idx) + 1'b1 + sida_pkg::LEN_W'(res.negative);
    end else if (state == sida_pkg::EMIT_DIGIT && out_ready && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  assign digit       = bcd[{idx, 2'b00} +: sida_pkg::DIGIT_W];
  assign character   = (state == sida_pkg::EMIT_SIGN) ? sida_pkg::CHAR_MINUS
                                                      : sida_pkg::CHAR_ZERO + {4'b0000, digit};
  assign text_length = len;
  assign is_last     = (state == sida_pkg::EMIT_DIGIT) && (idx == '0);

  // Every character is a minus sign or a decimal digit.
  `SIDA_ASSERT(a_char_range, out_valid |-> (character == sida_pkg::CHAR_MINUS || (character >= 8'd48 && character <= 8'd57)), "bad character")
  // The text length stays within one to eleven characters.
  `SIDA_ASSERT(a_len_range, out_valid |-> (text_length >= 4'd1 && text_length <= 4'd11), "bad text length")
  // The output goes quiet right after the last character of a text is taken.
  `SIDA_ASSERT(a_last_ends, (out_valid && out_ready && is_last) |=> !out_valid, "output after last character")

endmodule

### rtl/core/signed_int_to_decimal_ascii_top.sv
// Converts a 32-bit two's complement integer into its decimal ASCII text, one
// character per output request, most significant first, with a leading minus
// sign for negative values; every character carries the total text length
// and a last-character flag. The magnitude is converted bit serially
// (shift and add-three over ten BCD digits) once the input request is
// accepted; the emitter then sends one character per cycle while out_ready
// is high, up to 11 for the most negative value. A new input is taken as
// soon as the converter has handed its digits to the emitter, so conversion
// of one value overlaps the output of the previous one and the sustained
// rate is set by the 32-step conversion loop.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic [3:0]  text_length,
  output logic        is_last
);

  sida_pkg::conv_result_t res;
  logic                   res_valid;
  logic                   res_ready;

  // Bit-serial binary to BCD conversion.
  sida_bin2bcd u_bin2bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Character output, one character per request.
  sida_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .character   (character),
    .text_length (text_length),
    .is_last     (is_last)
  );

endmodule
